// ===== design/pts_pkg.sv =====
// Shared types and constants for the periodic timer slot table.
// No dependencies; imported by every module of the block.
`default_nettype none

package pts_pkg;

    // Microseconds in one millisecond.
    localparam logic [9:0] US_PER_MS = 10'd1000;

    // Most fired results one scan may report.
    localparam int MAX_RESULTS = 8;

    // Width of interval times microseconds-per-millisecond.
    localparam int PROD_W = 42;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_STOP   = 2'd1,
        OP_SCAN   = 2'd2,
        OP_SHIFT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FAILED  = 3'd1,
        ST_FIRED   = 3'd2,
        ST_NONE    = 3'd3,
        ST_SHIFTED = 3'd4
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [63:0] time_us;
        logic [31:0] period_ms;
        logic        single_shot;
        logic [3:0]  slot_id;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [3:0] result_id;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_msg;

    typedef struct packed {
        logic        single_shot;
        logic [31:0] period_ms;
        logic [63:0] expiry_us;
    } t_slot;

endpackage

`default_nettype wire

// ===== design/pts_out_reg.sv =====
// One-entry output register for result words.
// Depends on pts_pkg for the result types.
`default_nettype none

module pts_out_reg
    import pts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_res_msg i_msg,
    input  wire logic     i_stall,
    output logic          o_ready,
    output logic          o_valid,
    output t_result       o_res
);

    logic    r_valid;
    t_result r_res;

    // Take a new word when empty or when the held word leaves this cycle.
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_msg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_msg.valid) begin
            r_res <= i_msg.res;
        end
    end

endmodule

`default_nettype wire

// ===== design/pts_ctrl.sv =====
// Command sequencer: slot memory, used bits and per-slot read-modify-write.
// Depends on pts_pkg for command, result and slot types.
`default_nettype none

module pts_ctrl
    import pts_pkg::*;
#(
    parameter int TIMER_SLOTS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_ready,
    output t_res_msg  o_msg,
    output logic      o_done
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_CR_WR,
        S_SH_RD,
        S_SH_WR,
        S_SC_RD,
        S_SC_CMP,
        S_SC_ADV,
        S_SC_FIX,
        S_SC_PUSH,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_idx;
    logic [TIMER_SLOTS-1:0]  r_used;
    logic [PROD_W-1:0]       r_prod;
    logic [63:0]             r_sum;
    logic                    r_pend_v;
    logic [3:0]              r_pend_id;
    logic [3:0]              r_found;
    t_result                 r_res;

    t_slot                   r_mem [TIMER_SLOTS];
    t_slot                   r_rd;

    logic [IW-1:0] idx;
    logic          at_end;
    logic [3:0]    cur_id;
    logic [3:0]    stop_m1;
    logic [IW-1:0] stop_idx;
    logic          stop_ok;
    logic          due;
    logic [63:0]   prod64;
    logic [63:0]   fix_deadline;
    logic          mem_we;
    t_slot         mem_wdata;

    assign idx      = r_idx[IW-1:0];
    assign at_end   = (r_idx == CW'(TIMER_SLOTS));
    assign cur_id   = 4'({1'b0, idx} + 1'b1);
    assign stop_m1  = i_cmd.slot_id - 4'd1;
    assign stop_idx = IW'(stop_m1);
    assign stop_ok  = (i_cmd.slot_id != 4'd0)
                   && (32'(i_cmd.slot_id) <= 32'(TIMER_SLOTS))
                   && r_used[stop_idx];
    assign due      = (r_rd.expiry_us <= i_cmd.time_us);
    assign prod64   = 64'(r_prod);
    // Late even after one period: restart from now.
    assign fix_deadline = (r_sum <= i_cmd.time_us) ? (i_cmd.time_us + prod64) : r_sum;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rd;
        unique case (r_state)
            S_CR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = '{single_shot: i_cmd.single_shot,
                              period_ms:   i_cmd.period_ms,
                              expiry_us:   i_cmd.time_us + prod64};
            end
            S_SH_WR: begin
                mem_we              = 1'b1;
                mem_wdata.expiry_us = r_rd.expiry_us + i_cmd.time_us;
            end
            S_SC_FIX: begin
                mem_we              = 1'b1;
                mem_wdata.expiry_us = fix_deadline;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port, same address.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[idx] <= mem_wdata;
        end
        r_rd <= r_mem[idx];
    end

    always_comb begin
        o_msg.valid = (r_state == S_EMIT) || ((r_state == S_SC_PUSH) && r_pend_v);
        if (r_state == S_EMIT) begin
            o_msg.res = r_res;
        end else begin
            o_msg.res = '{status: ST_FIRED, result_id: r_pend_id, last: 1'b0};
        end
    end

    assign o_done = (r_state == S_EMIT) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_used   <= '0;
            r_pend_v <= 1'b0;
            r_found  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_pend_v <= 1'b0;
                    r_found  <= '0;
                    if (i_start) begin
                        unique case (i_cmd.op)
                            OP_CREATE: r_state <= S_FIND;
                            OP_STOP: begin
                                if (stop_ok) begin
                                    r_used[stop_idx] <= 1'b0;
                                    r_res <= '{status: ST_OK, result_id: 4'd0, last: 1'b1};
                                end else begin
                                    r_res <= '{status: ST_FAILED, result_id: 4'd0,
                                               last: 1'b1};
                                end
                                r_state <= S_EMIT;
                            end
                            OP_SCAN:  r_state <= S_SC_RD;
                            OP_SHIFT: r_state <= S_SH_RD;
                        endcase
                    end
                end
                S_FIND: begin
                    priority if (at_end) begin
                        r_res   <= '{status: ST_FAILED, result_id: 4'd0, last: 1'b1};
                        r_state <= S_EMIT;
                    end else if (!r_used[idx]) begin
                        r_prod  <= PROD_W'(i_cmd.period_ms) * PROD_W'(US_PER_MS);
                        r_state <= S_CR_WR;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CR_WR: begin
                    r_used[idx] <= 1'b1;
                    r_res   <= '{status: ST_OK, result_id: cur_id, last: 1'b1};
                    r_state <= S_EMIT;
                end
                S_SH_RD: begin
                    priority if (at_end) begin
                        r_res   <= '{status: ST_SHIFTED, result_id: 4'd0, last: 1'b1};
                        r_state <= S_EMIT;
                    end else if (r_used[idx]) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SH_WR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SH_RD;
                end
                S_SC_RD: begin
                    priority if (at_end || (r_found == 4'(MAX_RESULTS))) begin
                        if (r_pend_v) begin
                            r_res <= '{status: ST_FIRED, result_id: r_pend_id, last: 1'b1};
                        end else begin
                            r_res <= '{status: ST_NONE, result_id: 4'd0, last: 1'b1};
                        end
                        r_state <= S_EMIT;
                    end else if (r_used[idx]) begin
                        r_state <= S_SC_CMP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SC_CMP: begin
                    r_prod <= PROD_W'(r_rd.period_ms) * PROD_W'(US_PER_MS);
                    priority if (!due) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SC_RD;
                    end else if (r_rd.single_shot) begin
                        r_used[idx] <= 1'b0;
                        r_state     <= S_SC_PUSH;
                    end else begin
                        r_state <= S_SC_ADV;
                    end
                end
                S_SC_ADV: begin
                    r_sum   <= r_rd.expiry_us + prod64;
                    r_state <= S_SC_FIX;
                end
                S_SC_FIX: begin
                    r_state <= S_SC_PUSH;
                end
                S_SC_PUSH: begin
                    // Hold the new hit; the previous one goes out without last.
                    if (!r_pend_v || i_out_ready) begin
                        r_pend_v  <= 1'b1;
                        r_pend_id <= cur_id;
                        r_found   <= r_found + 4'd1;
                        r_idx     <= r_idx + 1'b1;
                        r_state   <= S_SC_RD;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= 4'(MAX_RESULTS))
        else $error("scan hit count exceeds limit");

    a_create_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CR_WR) |=> r_used[$past(idx)])
        else $error("created slot not marked used");

    a_oneshot_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_CMP && due && r_rd.single_shot) |=> !r_used[$past(idx)])
        else $error("fired one-shot slot still used");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_msg.valid && o_msg.res.last))
        else $error("command finished without a last word");

endmodule

`default_nettype wire

// ===== design/periodic_timer_slots_unit.sv =====
// Top level of the periodic timer slot table: input register, sequencer, output register.
// Depends on pts_pkg, pts_ctrl and pts_out_reg.
//
// Usage: one command word enters on the input channel (i_in_valid / o_in_stall);
// its result words leave on the output channel (o_out_valid / i_out_stall).
// Create, stop and shift give one word; scan gives one fired word per due slot
// (at most eight), or one nothing-due word, with o_last on the final word.
// A word is held in an input register while the sequencer walks the slot memory,
// one read-modify-write at a time, with one write port and one read port.
// Stop needs no walk of the memory; create walks to the first free slot (and fails
// at the end of a full table); shift and scan walk every slot, scan stopping
// once it has reported eight fired slots.
// The next command is accepted the cycle after the last word is handed over.
// Reset (i_rst_n low at a clock edge) marks every slot free and empties both
// registers; slot contents are not cleared. A stall on the output holds the
// current word steady, pausing the sequencer at its next word; input stays stalled.
`default_nettype none

module periodic_timer_slots_unit
    import pts_pkg::*;
#(
    parameter int TIMER_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [63:0] i_time_us,
    input  wire logic [31:0] i_period_ms,
    input  wire logic        i_single_shot,
    input  wire logic [3:0]  i_slot_id,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_result_id,
    output logic             o_last
);

    logic     r_cmd_v;
    t_cmd     r_cmd;
    logic     in_take;
    logic     cmd_done;
    logic     out_ready;
    t_res_msg res_msg;
    t_result  out_res;

    // Hold off new words until the current command has handed over its last word.
    assign o_in_stall = r_cmd_v;
    assign in_take    = i_in_valid && !r_cmd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v <= 1'b0;
        end else if (in_take) begin
            r_cmd_v <= 1'b1;
        end else if (cmd_done) begin
            r_cmd_v <= 1'b0;
        end
    end

    // Capture the command word; it stays put for the whole command.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= '{op: t_op'(i_cmd), time_us: i_time_us, period_ms: i_period_ms,
                       single_shot: i_single_shot, slot_id: i_slot_id};
        end
    end

    pts_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_cmd_v),
        .i_cmd       (r_cmd),
        .i_out_ready (out_ready),
        .o_msg       (res_msg),
        .o_done      (cmd_done)
    );

    pts_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (res_msg),
        .i_stall (i_out_stall),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_status    = out_res.status;
    assign o_result_id = out_res.result_id;
    assign o_last      = out_res.last;

endmodule

`default_nettype wire

// ===== verif/periodic_timer_slots_unit_test.sv =====
// Self-checking testbench for periodic_timer_slots_unit: a directed run and a random run.
// It keeps its own model of the timer table and checks every result word against it.
// Depends on pts_pkg and the periodic_timer_slots_unit RTL.
`default_nettype none

module periodic_timer_slots_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int SLOTS = 8;
    localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // One command word as the sender offers it; drain holds it back until the
    // block has handed over every result word of the earlier commands.
    typedef struct {
        t_op         op;
        logic [63:0] t_us;
        logic [31:0] iv_ms;
        logic        one;
        logic [3:0]  id;
        logic        drain;
    } t_timer_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_cmd = 2'd0;
    logic [63:0] i_time_us = 64'd0;
    logic [31:0] i_period_ms = 32'd0;
    logic        i_single_shot = 1'b0;
    logic [3:0]  i_slot_id = 4'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_result_id;
    logic        o_last;

    periodic_timer_slots_unit #(.TIMER_SLOTS(SLOTS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_time_us     (i_time_us),
        .i_period_ms   (i_period_ms),
        .i_single_shot (i_single_shot),
        .i_slot_id     (i_slot_id),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_result_id   (o_result_id),
        .o_last        (o_last)
    );

    // Shadow copy of the timer table.
    logic        tbl_used [SLOTS];
    logic        tbl_one  [SLOTS];
    logic [31:0] tbl_iv   [SLOTS];
    logic [63:0] tbl_dl   [SLOTS];

    t_timer_cmd cmd_words_q[$];      // commands not yet put on the bus
    t_result    timer_results_q[$];  // result words the block still owes
    t_timer_cmd cur_cmd;             // command currently on the bus

    int words_sent = 0;   // commands put on the bus
    int words_in = 0;     // commands the block has taken
    int n_items = 1;
    int mismatches = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] period_of(int s);
        return {32'd0, tbl_iv[s]} * 64'(US_PER_MS);
    endfunction

    // Apply one command to the shadow table and queue the words it must produce.
    function automatic void table_apply(t_timer_cmd c);
        t_result          w;
        logic [SLOTS-1:0] due;
        int               s;
        int               final_s;
        bit               placed;

        w.status = ST_OK;
        w.result_id = 4'd0;
        w.last = 1'b1;
        placed = 1'b0;
        case (c.op)
            OP_CREATE: begin
                // Take the lowest free slot, or fail when the table is full.
                w.status = ST_FAILED;
                for (s = 0; s < SLOTS; s++) begin
                    if (!placed && !tbl_used[s]) begin
                        placed = 1'b1;
                        tbl_used[s] = 1'b1;
                        tbl_one[s] = c.one;
                        tbl_iv[s] = c.iv_ms;
                        tbl_dl[s] = c.t_us + period_of(s);
                        w.status = ST_OK;
                        w.result_id = 4'(s + 1);
                    end
                end
                timer_results_q.push_back(w);
            end
            OP_STOP: begin
                // Id zero, ids past the table and ids of free slots all fail.
                if (c.id >= 4'd1 && c.id <= 4'(SLOTS) && tbl_used[c.id - 4'd1]) begin
                    tbl_used[c.id - 4'd1] = 1'b0;
                end else begin
                    w.status = ST_FAILED;
                end
                timer_results_q.push_back(w);
            end
            OP_SHIFT: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_used[s])
                        tbl_dl[s] = tbl_dl[s] + c.t_us;
                end
                w.status = ST_SHIFTED;
                timer_results_q.push_back(w);
            end
            default: begin
                // Scan: whether a slot is due does not depend on the others, so
                // find the due set first to know which word carries last.
                final_s = -1;
                for (s = 0; s < SLOTS; s++) begin
                    due[s] = tbl_used[s] && (tbl_dl[s] <= c.t_us);
                    if (due[s])
                        final_s = s;
                end
                if (final_s < 0) begin
                    w.status = ST_NONE;
                    timer_results_q.push_back(w);
                end
                for (s = 0; s < SLOTS; s++) begin
                    if (due[s]) begin
                        w.status = ST_FIRED;
                        w.result_id = 4'(s + 1);
                        w.last = (s == final_s);
                        timer_results_q.push_back(w);
                        if (tbl_one[s]) begin
                            tbl_used[s] = 1'b0;
                        end else begin
                            // Advance one period; if still late, skip the missed ones.
                            tbl_dl[s] = tbl_dl[s] + period_of(s);
                            if (tbl_dl[s] <= c.t_us)
                                tbl_dl[s] = c.t_us + period_of(s);
                        end
                    end
                end
            end
        endcase
    endfunction

    // Idle rates by run phase: sender light and receiver heavy, then swapped,
    // then no idling at all.
    function automatic int send_idle_pct();
        if (words_sent < n_items / 3)
            return 37;
        if (words_sent < (2 * n_items) / 3)
            return 78;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (words_sent < n_items / 3)
            return 78;
        if (words_sent < (2 * n_items) / 3)
            return 37;
        return 0;
    endfunction

    task automatic add_cmd(t_op op, logic [63:0] t_us, logic [31:0] iv_ms, logic one,
                           logic [3:0] id, logic drain);
        t_timer_cmd c;

        c.op = op;
        c.t_us = t_us;
        c.iv_ms = iv_ms;
        c.one = one;
        c.id = id;
        c.drain = drain;
        cmd_words_q.push_back(c);
    endtask

    // Sender: drop valid once the word is taken, then maybe offer the next one.
    // A word under stall stays on the bus unchanged.
    always @(negedge i_clk) begin
        logic nv;

        nv = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && words_in == words_sent)
                nv = 1'b0;
            if (!nv && cmd_words_q.size() > 0
                && $urandom_range(99) >= send_idle_pct()
                && (!cmd_words_q[0].drain
                    || (timer_results_q.size() == 0 && words_in == words_sent))) begin
                cur_cmd = cmd_words_q.pop_front();
                i_cmd <= cur_cmd.op;
                i_time_us <= cur_cmd.t_us;
                i_period_ms <= cur_cmd.iv_ms;
                i_single_shot <= cur_cmd.one;
                i_slot_id <= cur_cmd.id;
                words_sent++;
                nv = 1'b1;
            end
        end
        i_in_valid <= nv;
    end

    // Receiver: stall at random; once, hold off for a long stretch so that the
    // block backs up and stalls its input while the sender keeps offering.
    always @(negedge i_clk) begin
        logic st;

        st = 1'b0;
        if (!held_once && words_in >= 40) begin
            hold_left = 160;
            held_once = 1'b1;
        end
        if (hold_left > 0) begin
            st = 1'b1;
            hold_left--;
        end else if ($urandom_range(99) < recv_idle_pct()) begin
            st = 1'b1;
        end
        i_out_stall <= st;
    end

    // Monitor: update the shadow table on every taken command and check every
    // handed-over result word against the oldest owed word.
    always @(posedge i_clk) begin
        t_result want;

        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                table_apply(cur_cmd);
                words_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (timer_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: status %0d id %0d last %0d",
                             $time, o_status, o_result_id, o_last);
                end else begin
                    want = timer_results_q.pop_front();
                    if (o_status !== want.status || o_result_id !== want.result_id
                        || o_last !== want.last) begin
                        mismatches++;
                        // Values read as status/id/last.
                        $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.status, want.result_id, want.last,
                                 o_status, o_result_id, o_last);
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [63:0] gen_now;
        logic [63:0] delta;
        int          k;
        int          roll;
        int          s;

        for (s = 0; s < SLOTS; s++)
            tbl_used[s] = 1'b0;

        // Directed: empty table, bad stop ids, fill the table, overflow, a scan at
        // the top of the time range that fires every used slot with wrapped deadlines.
        add_cmd(OP_SCAN, 64'd0, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_STOP, 64'd0, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_STOP, 64'd0, 32'd0, 1'b0, 4'd1, 1'b0);
        add_cmd(OP_STOP, T_MAX, 32'hFFFF_FFFF, 1'b1, 4'd15, 1'b0);
        add_cmd(OP_STOP, 64'd0, 32'd0, 1'b0, 4'd9, 1'b0);
        add_cmd(OP_SHIFT, 64'd0, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_CREATE, 64'd0, 32'd0, 1'b1, 4'd0, 1'b0);
        add_cmd(OP_CREATE, T_MAX, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_CREATE, 64'd1000, 32'd1, 1'b0, 4'd0, 1'b0);
        for (k = 1; k <= 5; k++)
            add_cmd(OP_CREATE, 64'd0, 32'(k), 1'(k % 2), 4'd0, 1'b0);
        add_cmd(OP_CREATE, 64'd0, 32'd3, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_SCAN, 64'd500, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_SCAN, T_MAX, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_STOP, 64'd0, 32'd0, 1'b0, 4'd8, 1'b0);
        add_cmd(OP_STOP, 64'd0, 32'd0, 1'b0, 4'd8, 1'b0);
        add_cmd(OP_CREATE, 64'd2000, 32'd2, 1'b1, 4'd0, 1'b0);
        add_cmd(OP_SHIFT, T_MAX, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_SHIFT, 64'd5000, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_SCAN, 64'd0, 32'd0, 1'b0, 4'd0, 1'b0);
        add_cmd(OP_SCAN, 64'd100_000, 32'd0, 1'b0, 4'd0, 1'b0);

        // Random: a clock that moves forward, creates with short periods, scans at
        // the current time, stops mostly on real ids; a little noise on top.
        gen_now = 64'd100_000;
        for (k = 0; k < 220; k++) begin
            roll = $urandom_range(99);
            if (roll < 34) begin
                add_cmd(OP_CREATE, gen_now, $urandom_range(0, 12), 1'($urandom),
                        4'($urandom), (k == 0 || k == 120));
            end else if (roll < 64) begin
                gen_now = gen_now + 64'($urandom_range(0, 6000));
                add_cmd(OP_SCAN, gen_now, $urandom, 1'($urandom), 4'($urandom),
                        (k == 0 || k == 120));
            end else if (roll < 84) begin
                add_cmd(OP_STOP, {$urandom, $urandom}, $urandom, 1'($urandom),
                        ($urandom_range(99) < 85) ? 4'($urandom_range(1, SLOTS))
                                                  : 4'($urandom),
                        (k == 0 || k == 120));
            end else if (roll < 94) begin
                // Pause and resume: push deadlines out, pull them in by wrapping,
                // or now and then jump by a huge amount.
                case ($urandom_range(2))
                    0: delta = 64'($urandom_range(0, 3000));
                    1: delta = 64'd0 - 64'($urandom_range(0, 3000));
                    default: delta = {$urandom, $urandom};
                endcase
                add_cmd(OP_SHIFT, delta, $urandom, 1'($urandom), 4'($urandom),
                        (k == 0 || k == 120));
            end else begin
                add_cmd(t_op'($urandom_range(3)), {$urandom, $urandom}, $urandom,
                        1'($urandom), 4'($urandom), (k == 0 || k == 120));
            end
        end
        n_items = cmd_words_q.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to go in and every owed word to come out.
        while (cmd_words_q.size() > 0 || words_in != words_sent
               || timer_results_q.size() > 0)
            @(negedge i_clk);
        // Leave room for any stray word after the last one.
        repeat (80) @(posedge i_clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/pts_pkg.sv
design/pts_out_reg.sv
design/pts_ctrl.sv
design/periodic_timer_slots_unit.sv
verif/periodic_timer_slots_unit_test.sv
